// ----- rtl/core/button_gesture_detector_top_assert.svh -----
// Assertion macros used by the button gesture detector top module.
`ifndef BUTTON_GESTURE_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_GESTURE_DETECTOR_TOP_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define BGD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgd assertion failed");

// Check a consequent in the cycle after its antecedent.
`define BGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgd assertion failed");

`endif

// ----- rtl/core/bgd_pkg.sv -----
package bgd_pkg;

    localparam int TIME_W = 16;
    localparam int GST_W  = 3;
    localparam int CFG_IDX_W = 2;

    typedef logic [TIME_W-1:0] bgd_time_t;
    typedef logic [GST_W-1:0]  bgd_gesture_t;
    typedef logic [CFG_IDX_W-1:0] bgd_cfg_idx_t;

    localparam bgd_gesture_t GST_NONE   = 3'd0;
    localparam bgd_gesture_t GST_CLICK  = 3'd1;
    localparam bgd_gesture_t GST_DOUBLE = 3'd2;
    localparam bgd_gesture_t GST_HOLD   = 3'd3;
    localparam bgd_gesture_t GST_LONG   = 3'd4;

    localparam bgd_cfg_idx_t REG_DEBOUNCE  = 2'd0;
    localparam bgd_cfg_idx_t REG_DBL_GAP   = 2'd1;
    localparam bgd_cfg_idx_t REG_HOLD      = 2'd2;
    localparam bgd_cfg_idx_t REG_LONG_HOLD = 2'd3;

    localparam bgd_time_t RST_DEBOUNCE  = 16'd20;
    localparam bgd_time_t RST_DBL_GAP   = 16'd250;
    localparam bgd_time_t RST_HOLD      = 16'd1000;
    localparam bgd_time_t RST_LONG_HOLD = 16'd3000;

    typedef struct packed {
        bgd_time_t debounce_ms;
        bgd_time_t double_click_gap_ms;
        bgd_time_t hold_ms;
        bgd_time_t long_hold_ms;
    } bgd_cfg_t;

    typedef struct packed {
        logic      prev_level;
        bgd_time_t press_time;
        bgd_time_t release_time;
        logic      awaiting_second;
        logic      double_pending;
        logic      single_allowed;
        logic      skip_release;
        logic      hold_fired;
        logic      long_hold_fired;
    } bgd_state_t;

    localparam bgd_state_t RST_STATE = '{
        prev_level:      1'b1,
        press_time:      '0,
        release_time:    '0,
        awaiting_second: 1'b0,
        double_pending:  1'b0,
        single_allowed:  1'b1,
        skip_release:    1'b0,
        hold_fired:      1'b0,
        long_hold_fired: 1'b0
    };

endpackage

// ----- rtl/core/bgd_if.sv -----
interface bgd_smp_if import bgd_pkg::*;;
    logic      valid;
    logic      ready;
    logic      button_level;
    bgd_time_t time_ms;

    modport source (output valid, output button_level, output time_ms, input ready);
    modport sink   (input valid, input button_level, input time_ms, output ready);
endinterface

interface bgd_res_if import bgd_pkg::*;;
    logic         valid;
    logic         ready;
    bgd_gesture_t gesture;

    modport source (output valid, output gesture, input ready);
    modport sink   (input valid, input gesture, output ready);
endinterface

interface bgd_cfg_if import bgd_pkg::*;;
    logic         valid;
    logic         ready;
    bgd_cfg_idx_t index;
    bgd_time_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/button_gesture_detector_top.sv -----
// An accepted sample sits in the input register; its gesture is then registered in gesture_reg.
// Throughput: one sample per cycle unless res stalls; input register refills as result drains.
// The gesture state is a single set of flags and times, updated once per sample.
// Reset (rst_n low, asynchronous): valid flags, config and state (released) take defaults.
`include "button_gesture_detector_top_assert.svh"

module button_gesture_detector_top import bgd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bgd_smp_if.sink   smp,
    bgd_res_if.source res,
    bgd_cfg_if.sink   cfg
);

    bgd_cfg_t     cfg_q;
    logic         smp_valid_reg;
    logic         level_reg;
    bgd_time_t    time_reg;
    logic         res_valid_reg;
    bgd_gesture_t gesture_reg;
    bgd_gesture_t gesture_next;
    bgd_state_t   st_reg;
    bgd_state_t   st_next;
    logic         adv;
    bgd_time_t    since_up;
    bgd_time_t    since_down;

    bgd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    assign adv         = smp_valid_reg && (!res_valid_reg || res.ready);
    assign smp.ready   = !smp_valid_reg || adv;
    assign res.valid   = res_valid_reg;
    assign res.gesture = gesture_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg <= 1'b0;
        end
        else if (smp.ready)
        begin
            smp_valid_reg <= smp.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp.valid && smp.ready)
        begin
            level_reg <= smp.button_level;
            time_reg  <= smp.time_ms;
        end
    end

    always_comb
    begin
        st_next      = st_reg;
        gesture_next = GST_NONE;
        since_up     = time_reg - st_reg.release_time;
        since_down   = time_reg - st_reg.press_time;

        if (!level_reg && st_reg.prev_level && (since_up > cfg_q.debounce_ms))
        begin
            st_next.press_time      = time_reg;
            st_next.skip_release    = 1'b0;
            st_next.single_allowed  = 1'b1;
            st_next.hold_fired      = 1'b0;
            st_next.long_hold_fired = 1'b0;
            st_next.double_pending  = (since_up < cfg_q.double_click_gap_ms) &&
                                      !st_reg.double_pending && st_reg.awaiting_second;
            st_next.awaiting_second = 1'b0;
            since_down              = '0;
        end
        else if (level_reg && !st_reg.prev_level && (since_down > cfg_q.debounce_ms))
        begin
            if (!st_reg.skip_release)
            begin
                st_next.release_time = time_reg;
                since_up             = '0;
                if (!st_reg.double_pending)
                begin
                    st_next.awaiting_second = 1'b1;
                end
                else
                begin
                    gesture_next            = GST_DOUBLE;
                    st_next.double_pending  = 1'b0;
                    st_next.awaiting_second = 1'b0;
                    st_next.single_allowed  = 1'b0;
                end
            end
        end

        if (level_reg && (since_up >= cfg_q.double_click_gap_ms) && st_next.awaiting_second &&
            !st_next.double_pending && st_next.single_allowed && (gesture_next != GST_DOUBLE))
        begin
            gesture_next            = GST_CLICK;
            st_next.awaiting_second = 1'b0;
        end

        if (!level_reg && (since_down >= cfg_q.hold_ms))
        begin
            if (!st_next.hold_fired)
            begin
                gesture_next            = GST_HOLD;
                st_next.skip_release    = 1'b1;
                st_next.double_pending  = 1'b0;
                st_next.awaiting_second = 1'b0;
                st_next.hold_fired      = 1'b1;
            end
            if ((since_down >= cfg_q.long_hold_ms) && !st_next.long_hold_fired)
            begin
                gesture_next            = GST_LONG;
                st_next.long_hold_fired = 1'b1;
            end
        end

        st_next.prev_level = level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= RST_STATE;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            st_reg        <= st_next;
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gesture_reg <= gesture_next;
        end
    end

    `BGD_ASSERT_SAME(a_long_needs_hold, st_reg.long_hold_fired, st_reg.hold_fired)
    `BGD_ASSERT_SAME(a_double_excl_await, st_reg.double_pending, !st_reg.awaiting_second)
    `BGD_ASSERT_SAME(a_gesture_code, res_valid_reg, gesture_reg <= GST_LONG)
    `BGD_ASSERT_NEXT(a_advance_fills_result, adv, res_valid_reg)

endmodule

// ----- rtl/core/bgd_cfg_regs.sv -----
module bgd_cfg_regs import bgd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bgd_cfg_if.sink   cfg,
    output bgd_cfg_t  cfg_q
);

    bgd_cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms         <= RST_DEBOUNCE;
            cfg_reg.double_click_gap_ms <= RST_DBL_GAP;
            cfg_reg.hold_ms             <= RST_HOLD;
            cfg_reg.long_hold_ms        <= RST_LONG_HOLD;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_DEBOUNCE:  cfg_reg.debounce_ms         <= cfg.data;
                REG_DBL_GAP:   cfg_reg.double_click_gap_ms <= cfg.data;
                REG_HOLD:      cfg_reg.hold_ms             <= cfg.data;
                REG_LONG_HOLD: cfg_reg.long_hold_ms        <= cfg.data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ----- tb/sv/button_gesture_detector_top_tb.sv -----
`timescale 1ns / 1ps

module button_gesture_detector_top_tb;
    import bgd_pkg::*;

    localparam int unsigned STALL_LIMIT = 600;
    localparam int unsigned NUM_SETTINGS = 8;
    localparam int unsigned ITEMS_PER_SETTING = 200;

    class gesture_board;
        bgd_cfg_t     regs;
        bgd_state_t   btn;
        bgd_gesture_t pending_gestures[$];
        int unsigned  errors;
        int unsigned  samples;
        int unsigned  checked;
        int unsigned  tally[0:7];

        function new();
            regs = '{debounce_ms: RST_DEBOUNCE, double_click_gap_ms: RST_DBL_GAP,
                     hold_ms: RST_HOLD, long_hold_ms: RST_LONG_HOLD};
            btn = RST_STATE;
            errors = 0;
            samples = 0;
            checked = 0;
            foreach (tally[k]) tally[k] = 0;
        endfunction

        function void write_reg(bgd_cfg_idx_t idx, bgd_time_t val);
            case (idx)
                REG_DEBOUNCE:  regs.debounce_ms = val;
                REG_DBL_GAP:   regs.double_click_gap_ms = val;
                REG_HOLD:      regs.hold_ms = val;
                REG_LONG_HOLD: regs.long_hold_ms = val;
                default: ;
            endcase
        endfunction

        function void note_sample(logic lvl, bgd_time_t now);
            bgd_gesture_t ev;
            bgd_time_t    since_up;
            bgd_time_t    since_down;
            ev = GST_NONE;
            since_up = now - btn.release_time;
            since_down = now - btn.press_time;
            if (!lvl && btn.prev_level && since_up > regs.debounce_ms) begin
                btn.press_time = now;
                btn.skip_release = 1'b0;
                btn.single_allowed = 1'b1;
                btn.hold_fired = 1'b0;
                btn.long_hold_fired = 1'b0;
                btn.double_pending = (since_up < regs.double_click_gap_ms)
                                     && !btn.double_pending && btn.awaiting_second;
                btn.awaiting_second = 1'b0;
            end
            else if (lvl && !btn.prev_level && since_down > regs.debounce_ms) begin
                if (!btn.skip_release) begin
                    btn.release_time = now;
                    if (!btn.double_pending) begin
                        btn.awaiting_second = 1'b1;
                    end
                    else begin
                        ev = GST_DOUBLE;
                        btn.double_pending = 1'b0;
                        btn.awaiting_second = 1'b0;
                        btn.single_allowed = 1'b0;
                    end
                end
            end
            since_up = now - btn.release_time;
            since_down = now - btn.press_time;
            if (lvl && since_up >= regs.double_click_gap_ms && btn.awaiting_second
                && !btn.double_pending && btn.single_allowed && ev != GST_DOUBLE) begin
                ev = GST_CLICK;
                btn.awaiting_second = 1'b0;
            end
            if (!lvl && since_down >= regs.hold_ms) begin
                if (!btn.hold_fired) begin
                    ev = GST_HOLD;
                    btn.skip_release = 1'b1;
                    btn.double_pending = 1'b0;
                    btn.awaiting_second = 1'b0;
                    btn.hold_fired = 1'b1;
                end
                if (since_down >= regs.long_hold_ms && !btn.long_hold_fired) begin
                    ev = GST_LONG;
                    btn.long_hold_fired = 1'b1;
                end
            end
            btn.prev_level = lvl;
            pending_gestures.push_back(ev);
            tally[ev]++;
            samples++;
        endfunction

        function void check_gesture(bgd_gesture_t got);
            bgd_gesture_t want;
            if (pending_gestures.size() == 0) begin
                errors++;
                $display("%0t: unexpected gesture %0d, nothing expected", $time, got);
                return;
            end
            want = pending_gestures.pop_front();
            checked++;
            if (got !== want) begin
                errors++;
                $display("%0t: gesture mismatch, expected %0d, actual %0d", $time, want, got);
            end
        endfunction

        function int unsigned pending();
            return pending_gestures.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bgd_smp_if smp_ch();
    bgd_res_if res_ch();
    bgd_cfg_if cfg_ch();

    gesture_board board;
    bgd_time_t    clock_ms;
    int unsigned  smp_quiet;
    int unsigned  res_quiet;
    int unsigned  cfg_quiet;

    button_gesture_detector_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .smp   (smp_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned draw_wait(ref int unsigned quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic int unsigned span(int unsigned lo, int unsigned hi);
        return (hi <= lo) ? lo : $urandom_range(hi, lo);
    endfunction

    function automatic int unsigned below(int unsigned x);
        return (x > 0) ? x - 1 : 0;
    endfunction

    task automatic send_sample(input logic lvl, input bgd_time_t t);
        int unsigned w;
        w = draw_wait(smp_quiet);
        if (w > 0) begin
            smp_ch.valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        smp_ch.valid <= 1'b1;
        smp_ch.button_level <= lvl;
        smp_ch.time_ms <= t;
        do @(posedge clk); while (!smp_ch.ready);
        board.note_sample(lvl, t);
    endtask

    task automatic write_reg(input bgd_cfg_idx_t idx, input bgd_time_t val);
        int unsigned w;
        w = draw_wait(cfg_quiet);
        if (w > 0) begin
            cfg_ch.valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        board.write_reg(idx, val);
    endtask

    task automatic receive_gestures();
        int unsigned w;
        forever begin
            w = draw_wait(res_quiet);
            if (w > 0) begin
                res_ch.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            board.check_gesture(res_ch.gesture);
        end
    endtask

    // drain all expected gestures, then let the pipeline empty
    task automatic settle();
        smp_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_setting(input bgd_cfg_t s);
        settle();
        write_reg(REG_DEBOUNCE, s.debounce_ms);
        write_reg(REG_DBL_GAP, s.double_click_gap_ms);
        write_reg(REG_HOLD, s.hold_ms);
        write_reg(REG_LONG_HOLD, s.long_hold_ms);
        cfg_ch.valid <= 1'b0;
    endtask

    // hold one level for dur ms, spread over n samples; the first sample is the edge
    task automatic dwell(input logic lvl, input int unsigned dur, input int unsigned n);
        bgd_time_t base;
        base = clock_ms;
        send_sample(lvl, clock_ms);
        for (int i = 1; i < n; i++) begin
            clock_ms = base + bgd_time_t'(dur * i / n);
            send_sample(lvl, clock_ms);
        end
        clock_ms = base + bgd_time_t'(dur);
    endtask

    task automatic run_directed();
        send_sample(1'b1, 16'd0);
        send_sample(1'b0, 16'd100);
        send_sample(1'b1, 16'd150);
        send_sample(1'b0, 16'd200);
        send_sample(1'b1, 16'd260);
        send_sample(1'b1, 16'd600);
        send_sample(1'b0, 16'd700);
        send_sample(1'b1, 16'd750);
        send_sample(1'b1, 16'd1100);
        send_sample(1'b0, 16'd2000);
        send_sample(1'b0, 16'd3000);
        send_sample(1'b0, 16'd5000);
        send_sample(1'b1, 16'd5100);
        send_sample(1'b1, 16'd5110);
        send_sample(1'b0, 16'd5115);
        send_sample(1'b1, 16'd5120);
        send_sample(1'b0, 16'd5125);
        send_sample(1'b0, 16'hFFFF);
        send_sample(1'b1, 16'd0);
        send_sample(1'b1, 16'd400);
        send_sample(1'b0, 16'd300);
        send_sample(1'b1, 16'd500);
        settle();
        write_reg(REG_HOLD, 16'd50);
        write_reg(REG_LONG_HOLD, 16'd30);
        cfg_ch.valid <= 1'b0;
        send_sample(1'b0, 16'd900);
        send_sample(1'b0, 16'd960);
        clock_ms = 16'd1000;
    endtask

    function automatic bgd_cfg_t pick_setting(int unsigned p);
        bgd_cfg_t s;
        s = '{debounce_ms: RST_DEBOUNCE, double_click_gap_ms: RST_DBL_GAP,
              hold_ms: RST_HOLD, long_hold_ms: RST_LONG_HOLD};
        case (p)
            0: s = '{16'd5, 16'd40, 16'd120, 16'd300};
            1: s = '{16'd0, 16'd0, 16'd0, 16'd0};
            2: s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            3: s = '{16'd0, 16'hFFFF, 16'd200, 16'd100};
            4: s = '{16'd2, 16'd30, 16'd80, 16'd80};
            5: s = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd0};
            6:
            begin
                s.debounce_ms = bgd_time_t'($urandom_range(0, 60));
                s.double_click_gap_ms = bgd_time_t'($urandom_range(0, 500));
                s.hold_ms = bgd_time_t'($urandom_range(0, 2500));
                s.long_hold_ms = bgd_time_t'($urandom_range(0, 5000));
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic random_traffic(input int unsigned budget);
        int unsigned first;
        int unsigned d;
        int unsigned g;
        int unsigned h;
        int unsigned l;
        int unsigned flips;
        first = board.samples;
        d = board.regs.debounce_ms;
        g = board.regs.double_click_gap_ms;
        h = board.regs.hold_ms;
        l = board.regs.long_hold_ms;
        while (board.samples - first < budget) begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    dwell(1'b0, span(d + 1, below(h)), $urandom_range(1, 4));
                    dwell(1'b1, span(g, g + d + 100), $urandom_range(1, 4));
                end
                2, 3:
                begin
                    dwell(1'b0, span(d + 1, d + 80), $urandom_range(1, 3));
                    dwell(1'b1, span(d + 1, below(g)), $urandom_range(1, 3));
                    dwell(1'b0, span(d + 1, d + 80), $urandom_range(1, 3));
                    dwell(1'b1, span(g, g + d + 100), $urandom_range(1, 4));
                end
                4:
                begin
                    dwell(1'b0, span(h, below(l)), $urandom_range(2, 5));
                    dwell(1'b1, span(d + 1, g + d + 100), $urandom_range(1, 4));
                end
                5:
                begin
                    dwell(1'b0, span(l, l + 500), $urandom_range(2, 6));
                    dwell(1'b1, span(d + 1, g + d + 100), $urandom_range(1, 4));
                end
                6:
                begin
                    flips = $urandom_range(2, 6);
                    for (int k = 0; k < flips; k++)
                        dwell(k[0], span(0, d), 1);
                    dwell(1'b1, span(g, g + d + 100), $urandom_range(1, 3));
                end
                default:
                begin
                    clock_ms = bgd_time_t'($urandom);
                    send_sample(1'($urandom_range(0, 1)), clock_ms);
                end
            endcase
        end
    endtask

    initial
    begin : watchdog
        int unsigned idle_edges;
        idle_edges = 0;
        while (idle_edges < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_edges = 0;
            else
                idle_edges++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("** button_gesture_detector_top: FAILED **");
        $finish;
    end

    initial
    begin
        board = new();
        smp_quiet = 0;
        res_quiet = 0;
        cfg_quiet = 0;
        clock_ms = '0;
        rst_n <= 1'b0;
        smp_ch.valid <= 1'b0;
        smp_ch.button_level <= 1'b1;
        smp_ch.time_ms <= '0;
        res_ch.ready <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_DEBOUNCE;
        cfg_ch.data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            receive_gestures();
        join_none
        run_directed();
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            apply_setting(pick_setting(p));
            random_traffic(ITEMS_PER_SETTING);
        end
        settle();
        repeat (8) @(posedge clk);
        $display("Ran %0d samples over %0d register settings; %0d gestures checked.",
                 board.samples, NUM_SETTINGS + 2, board.checked);
        $display("Expected events: click %0d, double %0d, hold %0d, long hold %0d.",
                 board.tally[GST_CLICK], board.tally[GST_DOUBLE], board.tally[GST_HOLD],
                 board.tally[GST_LONG]);
        if (board.errors == 0)
            $display("** button_gesture_detector_top: PASSED **");
        else
            $display("** button_gesture_detector_top: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/bgd_pkg.sv
rtl/core/bgd_if.sv
rtl/core/bgd_cfg_regs.sv
rtl/core/button_gesture_detector_top.sv
tb/sv/button_gesture_detector_top_tb.sv
